>>> design/spnc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the shortest path / negative cycle block.
// No dependencies.
package spnc_pkg;

  localparam int NODE_W   = 9;
  localparam int WEIGHT_W = 16;
  localparam int DIST_W   = 32;
  localparam int PCNT_W   = 10;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_RUN   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NEG  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic signed [DIST_W-1:0] DIST_MAX = 32'sh7fffffff;
  localparam logic signed [DIST_W-1:0] DIST_MIN = 32'sh80000000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_WR,
    S_CLR,
    S_INIT,
    S_POP,
    S_POP_W,
    S_LOAD_U,
    S_EDGE,
    S_EDGE_W,
    S_RELAX,
    S_READ_W,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                     better;
    logic signed [DIST_W-1:0] cand;
  } relax_t;

endpackage

>>> design/spnc_relax.sv
`timescale 1ns / 1ps
// Shared relaxation unit: saturating distance add and improvement compare.
// Depends on spnc_pkg.
module spnc_relax (
  input  logic signed [spnc_pkg::DIST_W-1:0]   du,
  input  logic signed [spnc_pkg::WEIGHT_W-1:0] w,
  input  logic signed [spnc_pkg::DIST_W-1:0]   cur,
  input  logic                                 known,
  output spnc_pkg::relax_t                     res
);
  import spnc_pkg::*;

  logic signed [DIST_W:0]   sum;
  logic signed [DIST_W-1:0] cand;

  assign sum = {du[DIST_W-1], du} + (DIST_W + 1)'(w);

  always_comb begin
    if (sum[DIST_W] != sum[DIST_W-1]) begin
      cand = sum[DIST_W] ? DIST_MIN : DIST_MAX;
    end else begin
      cand = sum[DIST_W-1:0];
    end
  end

  assign res.cand   = cand;
  assign res.better = !known || (cand < cur);

endmodule

>>> design/shortest_path_negative_cycle.sv
`timescale 1ns / 1ps
// Top level: queue-based Bellman-Ford engine with edge store and work queue.
// Depends on spnc_pkg and spnc_relax.
//
// Edges are loaded into per-node adjacency lists (newest first); a run from a
// source relaxes edges through one shared saturating add/compare unit under a
// small sequencer, and reports a negative cycle once any node is pushed more
// than node_count times. Distances are read back one node at a time. One item
// is worked at a time; a finished result sits in the output register while the
// next item is taken. An add edge goes through accept, table write and result
// load (no write when it stores nothing), a read through accept, read wait and
// result load (no wait for a node out of range), a clear through accept and
// result load. The result shows up the cycle after it is loaded, and the next
// item can be taken in that cycle. A run clears the per-node reached, queued
// and push-count stores, seeds the source if in range, then per node taken off
// the queue pops it, waits on the reads and loads its distance and list head,
// and per edge fetches it, reads its head's entries, relaxes a head in range;
// it loads the result on an empty queue or a negative cycle. The list heads
// carry valid bits cleared at once.
module shortest_path_negative_cycle #(
  parameter int NODES = 256,
  parameter int EDGES = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [spnc_pkg::NODE_W-1:0]           cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            operation,
  input  logic [spnc_pkg::NODE_W-1:0]           first_node,
  input  logic [spnc_pkg::NODE_W-1:0]           second_node,
  input  logic signed [spnc_pkg::WEIGHT_W-1:0]  weight,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [1:0]                            status,
  output logic signed [spnc_pkg::DIST_W-1:0]    distance,
  output logic                                  reached
);
  import spnc_pkg::*;

  localparam int NW = $clog2(NODES);
  localparam int EW = $clog2(EDGES);
  localparam int LW = $clog2(EDGES + 1);

  state_t state, state_next;

  // configuration
  logic [NODE_W-1:0] node_count;
  logic [NODE_W-1:0] n_act;

  // memories
  logic [LW-1:0]              head_mem   [NODES];
  logic [NODE_W-1:0]          edge_tgt   [EDGES];
  logic [LW-1:0]              edge_lnk   [EDGES];
  logic signed [WEIGHT_W-1:0] edge_wt    [EDGES];
  logic signed [DIST_W-1:0]   best_mem   [NODES];
  logic [PCNT_W-1:0]          pc_mem     [NODES];
  logic [NODE_W-1:0]          queue_mem  [NODES];
  logic                       known_mem  [NODES];
  logic                       queued_mem [NODES];

  // list head valid bits
  logic head_vld [NODES];

  // registered read data
  logic [LW-1:0]              head_q;
  logic                       head_vld_q;
  logic signed [DIST_W-1:0]   best_q;
  logic [PCNT_W-1:0]          pc_q;
  logic                       known_q;
  logic                       queued_q;
  logic [NODE_W-1:0]          q_q;
  logic [NODE_W-1:0]          e_tgt_q;
  logic [LW-1:0]              e_lnk_q;
  logic signed [WEIGHT_W-1:0] e_wt_q;

  // queue and edge bookkeeping
  logic [NW-1:0] q_rd, q_wr;
  logic [NW:0]   q_len;
  logic [LW-1:0] edges_used;
  logic          ran;

  // item and walk registers
  logic [NW-1:0]              a_idx;
  logic [NODE_W-1:0]          b_q;
  logic signed [WEIGHT_W-1:0] w_q;
  logic                       src_ok_q;
  logic [NW-1:0]              clr_idx;
  logic signed [DIST_W-1:0]   du;
  logic [LW-1:0]              link;
  logic [NW-1:0]              v_idx;
  logic [NODE_W-1:0]          v_node;
  logic signed [WEIGHT_W-1:0] ew_q;
  logic [1:0]                 res_status;
  logic signed [DIST_W-1:0]   res_dist;
  logic                       res_reached;

  // control
  logic              accept;
  logic [NW-1:0]     idx_in;
  logic [NW-1:0]     u_idx;
  logic [NW-1:0]     tgt_idx;
  logic              in_node_ok, pair_ok, src_ok, tgt_ok;
  logic              table_full, link_end;
  logic              add_wr, clr_wr, init_wr, relax_wr, push, neg_hit, out_load;
  logic [PCNT_W-1:0] cnt;
  logic [NW-1:0]     head_raddr, best_raddr, known_raddr;
  relax_t            rx;

  always_comb begin
    if (node_count == '0) begin
      n_act = NODE_W'(1);
    end else if (32'(node_count) > NODES) begin
      n_act = NODE_W'(NODES);
    end else begin
      n_act = node_count;
    end
  end

  assign in_ready   = (state == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign idx_in     = NW'(32'(first_node) - 32'd1);
  assign u_idx      = NW'(32'(q_q) - 32'd1);
  assign tgt_idx    = NW'(32'(e_tgt_q) - 32'd1);
  assign in_node_ok = (first_node != '0) && (32'(first_node) <= NODES);
  assign pair_ok    = in_node_ok && (second_node != '0) && (32'(second_node) <= NODES);
  assign src_ok     = (first_node != '0) && (first_node <= n_act);
  assign tgt_ok     = (e_tgt_q != '0) && (e_tgt_q <= n_act);
  assign table_full = (32'(edges_used) >= EDGES);
  assign link_end   = (link == '0) || (32'(link) > EDGES);

  // push counts are cleared at run start, so the stored count is always valid
  assign cnt     = pc_q + PCNT_W'(1);
  assign neg_hit = cnt > PCNT_W'(n_act);

  assign head_raddr  = (state == S_IDLE) ? idx_in : u_idx;
  assign known_raddr = (state == S_IDLE) ? idx_in : tgt_idx;
  always_comb begin
    case (state)
      S_IDLE:  best_raddr = idx_in;
      S_POP_W: best_raddr = u_idx;
      default: best_raddr = tgt_idx;
    endcase
  end

  spnc_relax u_relax (
    .du    (du),
    .w     (ew_q),
    .cur   (best_q),
    .known (known_q),
    .res   (rx)
  );

  // sequencer: next state and strobes
  always_comb begin
    state_next = state;
    add_wr     = 1'b0;
    clr_wr     = 1'b0;
    init_wr    = 1'b0;
    relax_wr   = 1'b0;
    push       = 1'b0;
    out_load   = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (operation)
            OP_ADD: begin
              state_next = (pair_ok && !table_full) ? S_ADD_WR : S_DONE;
            end
            OP_RUN: begin
              state_next = S_CLR;
            end
            OP_READ: begin
              state_next = in_node_ok ? S_READ_W : S_DONE;
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_ADD_WR: begin
        add_wr     = 1'b1;
        state_next = S_DONE;
      end
      S_CLR: begin
        // drop the per-node marks of the last run, one node a cycle
        clr_wr = 1'b1;
        if (32'(clr_idx) == NODES - 1) begin
          state_next = src_ok_q ? S_INIT : S_DONE;
        end
      end
      S_INIT: begin
        init_wr    = 1'b1;
        state_next = S_POP;
      end
      S_POP:    state_next = (q_len == '0) ? S_DONE : S_POP_W;
      S_POP_W:  state_next = S_LOAD_U;
      S_LOAD_U: state_next = S_EDGE;
      S_EDGE:   state_next = link_end ? S_POP : S_EDGE_W;
      S_EDGE_W: state_next = tgt_ok ? S_RELAX : S_EDGE;
      S_RELAX: begin
        relax_wr = rx.better;
        push     = rx.better && !queued_q;
        if (push && neg_hit) begin
          state_next = S_DONE;
        end else begin
          state_next = S_EDGE;
        end
      end
      S_READ_W: state_next = S_DONE;
      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // memories: registered reads, one write port each
  always_ff @(posedge clk) begin
    head_q     <= head_mem[head_raddr];
    head_vld_q <= head_vld[head_raddr];
    best_q     <= best_mem[best_raddr];
    known_q    <= known_mem[known_raddr];
    queued_q   <= queued_mem[tgt_idx];
    pc_q       <= pc_mem[tgt_idx];
    q_q        <= queue_mem[q_rd];
    e_tgt_q    <= edge_tgt[EW'(link - LW'(1))];
    e_lnk_q    <= edge_lnk[EW'(link - LW'(1))];
    e_wt_q     <= edge_wt[EW'(link - LW'(1))];
    if (add_wr) begin
      edge_tgt[EW'(edges_used)] <= b_q;
      edge_lnk[EW'(edges_used)] <= head_vld_q ? head_q : '0;
      edge_wt[EW'(edges_used)]  <= w_q;
      head_mem[a_idx]           <= edges_used + LW'(1);
    end
    if (clr_wr) begin
      known_mem[clr_idx]  <= 1'b0;
      queued_mem[clr_idx] <= 1'b0;
      pc_mem[clr_idx]     <= '0;
    end
    if (init_wr) begin
      best_mem[a_idx]   <= '0;
      known_mem[a_idx]  <= 1'b1;
      queued_mem[a_idx] <= 1'b1;
      pc_mem[a_idx]     <= PCNT_W'(1);
      queue_mem[0]      <= NODE_W'(a_idx) + NODE_W'(1);
    end
    if (state == S_POP_W) begin
      queued_mem[u_idx] <= 1'b0;
    end
    if (relax_wr) begin
      best_mem[v_idx]  <= rx.cand;
      known_mem[v_idx] <= 1'b1;
    end
    if (push) begin
      queue_mem[q_wr]   <= v_node;
      queued_mem[v_idx] <= 1'b1;
      pc_mem[v_idx]     <= cnt;
    end
  end

  // control state: head valid bits, queue pointers, edge count, config, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NODES; i++) begin
        head_vld[i] <= 1'b0;
      end
      q_rd       <= '0;
      q_wr       <= '0;
      q_len      <= '0;
      edges_used <= '0;
      ran        <= 1'b0;
      node_count <= NODE_W'(256);
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        node_count <= cfg_data;
      end
      if (accept && operation == OP_RUN) begin
        // start of run: empty the queue; the clearing pass drops the marks
        ran   <= 1'b1;
        q_rd  <= '0;
        q_wr  <= '0;
        q_len <= '0;
      end
      if (accept && operation == OP_CLEAR) begin
        for (int i = 0; i < NODES; i++) begin
          head_vld[i] <= 1'b0;
        end
        edges_used <= '0;
      end
      if (add_wr) begin
        head_vld[a_idx] <= 1'b1;
        edges_used      <= edges_used + LW'(1);
      end
      if (init_wr) begin
        q_wr  <= NW'(1);
        q_len <= (NW + 1)'(1);
      end
      if (state == S_POP && q_len != '0) begin
        q_rd  <= (32'(q_rd) == NODES - 1) ? '0 : q_rd + NW'(1);
        q_len <= q_len - (NW + 1)'(1);
      end
      if (push) begin
        q_wr  <= (32'(q_wr) == NODES - 1) ? '0 : q_wr + NW'(1);
        q_len <= q_len + (NW + 1)'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers: item fields, walk state, result
  always_ff @(posedge clk) begin
    if (accept) begin
      a_idx       <= idx_in;
      b_q         <= second_node;
      w_q         <= weight;
      src_ok_q    <= src_ok;
      clr_idx     <= '0;
      res_status  <= (operation == OP_ADD && pair_ok && table_full) ? ST_FULL : ST_OK;
      res_dist    <= '0;
      res_reached <= 1'b0;
    end
    if (state == S_CLR) begin
      clr_idx <= clr_idx + NW'(1);
    end
    if (state == S_LOAD_U) begin
      du   <= best_q;
      link <= head_vld_q ? head_q : '0;
    end
    if (state == S_EDGE_W) begin
      link   <= e_lnk_q;
      ew_q   <= e_wt_q;
      v_idx  <= tgt_idx;
      v_node <= e_tgt_q;
    end
    if (push && neg_hit) begin
      res_status <= ST_NEG;
    end
    // nothing is reached before the first run
    if (state == S_READ_W && ran && known_q) begin
      res_dist    <= best_q;
      res_reached <= 1'b1;
    end
    if (out_load) begin
      status   <= res_status;
      distance <= res_dist;
      reached  <= res_reached;
    end
  end

  // queue never holds more entries than nodes
  a_qlen : assert property (@(posedge clk) disable iff (rst) 32'(q_len) <= NODES)
    else $error("work queue over capacity");

  // a pending result is handed over on the next edge once the slot is free
  a_load : assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !out_valid) |=> (out_valid && state == S_IDLE))
    else $error("result not loaded");

  // unreached nodes read zero distance
  a_zero : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !reached) |-> (distance == '0))
    else $error("distance without reach");

  // a reached read always reports ok status
  a_rdok : assert property (@(posedge clk) disable iff (rst)
    (out_valid && reached) |-> (status == ST_OK))
    else $error("read with bad status");

endmodule
